### rtl/bsrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the banded sparse row store.
package bsrs_pkg;

	localparam int ACC_W = 54;

	typedef enum logic [1:0] {
		K_WRITE = 2'd0,
		K_READ  = 2'd1,
		K_LOAD  = 2'd2,
		K_MUL   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_NONE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_ROWS = 2'd0,
		CFG_COLS = 2'd1,
		CFG_BAND = 2'd2,
		CFG_NONE = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_FILL,
		S_RD,
		S_CHK,
		S_VEC,
		S_MISS,
		S_MV_RD,
		S_MV_WR,
		S_SUM,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [6:0] rows_in_use;
		logic [6:0] columns_in_use;
		logic [3:0] band_in_use;
	} cfg_t;

	typedef struct packed {
		logic        clr;
		logic        en;
		logic [31:0] a;
		logic [31:0] b;
	} mac_ctl_t;

endpackage

### rtl/bsrs_mac.sv
`timescale 1ns / 1ps
// Shared multiply, round and accumulate unit with saturated sum.
module bsrs_mac import bsrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  mac_ctl_t    ctl,
	output logic        busy,
	output logic [31:0] sum
);

	logic signed [63:0]      prod_s1;
	logic                    vld_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [63:0]      rnd;

	localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] MINV = ACC_W'(-64'sd2147483648);

	assign rnd = (prod_s1 + 64'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctl.en;
			if (ctl.clr)
				acc_q <= '0;
			else if (vld_s1)
				acc_q <= acc_q + ACC_W'(rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en)
			prod_s1 <= $signed(ctl.a) * $signed(ctl.b);
	end

	assign busy = vld_s1;

	always_comb begin
		priority if (acc_q > MAXV)
			sum = 32'h7FFF_FFFF;
		else if (acc_q < MINV)
			sum = 32'h8000_0000;
		else
			sum = acc_q[31:0];
	end

endmodule

### rtl/bsrs_seq.sv
`timescale 1ns / 1ps
// Item sequencer with slot, fill and vector memories.
module bsrs_seq import bsrs_pkg::*; #(
	parameter int ROWS = 64,
	parameter int COLS = 64,
	parameter int BAND = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [5:0]  row,
	input  logic [5:0]  column,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [3:0]  row_fill,
	output logic [1:0]  status,
	output mac_ctl_t    mac_ctl,
	input  logic        mac_busy,
	input  logic [31:0] mac_sum
);

	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int VW   = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int KW   = (BAND > 1) ? $clog2(BAND) : 1;
	localparam int FW   = $clog2(BAND + 1);
	localparam int BW   = (FW > 4) ? FW : 4;
	localparam int SD   = 1 << (RW + KW);
	localparam int NCLR = (ROWS > COLS) ? ROWS : COLS;
	localparam int CLW  = $clog2(NCLR + 1);

	state_t state_q, state_d;

	kind_t       kind_q;
	logic [5:0]  row_q, col_q;
	logic [31:0] val_q;
	logic        rok_q, cok_q;
	logic [FW-1:0] fill_q, k_q, fout_q;
	logic [31:0] res_q;
	status_t     st_q;
	logic [CLW-1:0] clr_q;
	logic        ov_q;
	logic [31:0] ov_res_q;
	logic [3:0]  ov_fill_q;
	status_t     ov_st_q;

	logic [FW-1:0] fill_mem [ROWS];
	logic [31:0]   vec_mem  [COLS];
	logic [31:0]   sv_mem   [SD];
	logic [5:0]    sc_mem   [SD];

	logic [FW-1:0] fill_rd_q;
	logic [31:0]   vec_rd_q, sv_rd_q;
	logic [5:0]    sc_rd_q;

	logic              fill_we, vec_we, slot_we, slot_re, vec_re;
	logic [RW-1:0]     fill_wa, fill_ra;
	logic [FW-1:0]     fill_wd;
	logic [VW-1:0]     vec_wa, vec_ra;
	logic [31:0]       vec_wd, slot_wv;
	logic [5:0]        slot_wc;
	logic [RW+KW-1:0]  slot_wa, slot_ra;

	logic accept, rok_in, cok_in, hit, more, full, zero_val, done_ld;

	assign accept   = in_valid && in_ready;
	assign rok_in   = ({1'b0, row} < cfg.rows_in_use) && (11'(row) < 11'(ROWS));
	assign cok_in   = ({1'b0, column} < cfg.columns_in_use) && (11'(column) < 11'(COLS));
	assign hit      = (sc_rd_q == col_q);
	assign more     = (k_q + 1'b1) < fill_q;
	assign full     = (BW'(fill_q) >= BW'(cfg.band_in_use)) || (fill_q >= FW'(BAND));
	assign zero_val = (val_q == '0);
	assign done_ld  = (state_q == S_DONE) && (!ov_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:   if (clr_q == CLW'(NCLR - 1)) state_d = S_IDLE;
			S_IDLE:  if (accept) state_d = S_FILL;
			S_FILL: begin
				unique case (kind_q)
					K_LOAD: state_d = S_DONE;
					K_MUL: begin
						if (!rok_q) state_d = S_DONE;
						else if (fill_rd_q == '0) state_d = S_SUM;
						else state_d = S_RD;
					end
					default: begin
						if (!(rok_q && cok_q)) state_d = S_DONE;
						else if (fill_rd_q == '0) state_d = S_MISS;
						else state_d = S_RD;
					end
				endcase
			end
			S_RD:    state_d = S_CHK;
			S_CHK: begin
				if (kind_q == K_MUL) state_d = S_VEC;
				else if (hit) begin
					if (kind_q == K_WRITE && zero_val && more) state_d = S_MV_RD;
					else state_d = S_DONE;
				end else state_d = more ? S_RD : S_MISS;
			end
			S_VEC:   state_d = more ? S_RD : S_SUM;
			S_MISS:  state_d = S_DONE;
			S_MV_RD: state_d = S_MV_WR;
			S_MV_WR: state_d = more ? S_MV_RD : S_DONE;
			S_SUM:   if (!mac_busy) state_d = S_DONE;
			S_DONE:  if (done_ld) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		in_ready = (state_q == S_IDLE);
		fill_we  = 1'b0;
		fill_wa  = RW'(row_q);
		fill_wd  = fill_q;
		fill_ra  = RW'(row);
		vec_we   = 1'b0;
		vec_wa   = VW'(col_q);
		vec_wd   = val_q;
		vec_re   = 1'b0;
		vec_ra   = VW'(sc_rd_q);
		slot_we  = 1'b0;
		slot_wa  = {RW'(row_q), KW'(k_q)};
		slot_wv  = val_q;
		slot_wc  = col_q;
		slot_re  = 1'b0;
		slot_ra  = {RW'(row_q), KW'(k_q)};
		mac_ctl  = '{clr: accept, en: 1'b0, a: sv_rd_q, b: vec_rd_q};
		unique case (state_q)
			S_CLR: begin
				fill_we = (clr_q < CLW'(ROWS));
				fill_wa = RW'(clr_q);
				fill_wd = '0;
				vec_we  = (clr_q < CLW'(COLS));
				vec_wa  = VW'(clr_q);
				vec_wd  = '0;
			end
			S_FILL:  vec_we = (kind_q == K_LOAD) && cok_q;
			S_RD, S_MV_RD: slot_re = 1'b1;
			S_CHK: begin
				vec_re = (kind_q == K_MUL);
				if (kind_q == K_WRITE && hit) begin
					if (!zero_val) slot_we = 1'b1;
					else if (!more) begin
						fill_we = 1'b1;
						fill_wd = fill_q - 1'b1;
					end
				end
			end
			S_VEC:   mac_ctl.en = 1'b1;
			S_MISS: begin
				if (kind_q == K_WRITE && !zero_val && !full) begin
					slot_we = 1'b1;
					slot_wa = {RW'(row_q), KW'(fill_q)};
					fill_we = 1'b1;
					fill_wd = fill_q + 1'b1;
				end
			end
			S_MV_WR: begin
				slot_we = 1'b1;
				slot_wa = {RW'(row_q), KW'(k_q - 1'b1)};
				slot_wv = sv_rd_q;
				slot_wc = sc_rd_q;
				if (!more) begin
					fill_we = 1'b1;
					fill_wd = fill_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_wa] <= fill_wd;
		fill_rd_q <= fill_mem[fill_ra];
		if (vec_we) vec_mem[vec_wa] <= vec_wd;
		if (vec_re) vec_rd_q <= vec_mem[vec_ra];
		if (slot_we) begin
			sv_mem[slot_wa] <= slot_wv;
			sc_mem[slot_wa] <= slot_wc;
		end
		if (slot_re) begin
			sv_rd_q <= sv_mem[slot_ra];
			sc_rd_q <= sc_mem[slot_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
			if (done_ld) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			row_q  <= row;
			col_q  <= column;
			val_q  <= value;
			rok_q  <= rok_in;
			cok_q  <= cok_in;
			k_q    <= '0;
		end
		unique case (state_q)
			S_FILL: begin
				fill_q <= fill_rd_q;
				fout_q <= rok_q ? fill_rd_q : '0;
				res_q  <= '0;
				unique case (kind_q)
					K_LOAD:  st_q <= cok_q ? ST_OK : ST_RANGE;
					K_MUL:   st_q <= rok_q ? ST_OK : ST_RANGE;
					default: st_q <= (rok_q && cok_q) ? ST_OK : ST_RANGE;
				endcase
			end
			S_CHK: begin
				if (kind_q != K_MUL) begin
					if (hit) begin
						if (kind_q == K_READ) res_q <= sv_rd_q;
						else if (zero_val) begin
							if (more) k_q <= k_q + 1'b1;
							else fout_q <= fill_q - 1'b1;
						end
					end else if (more) k_q <= k_q + 1'b1;
				end
			end
			S_VEC:   if (more) k_q <= k_q + 1'b1;
			S_MISS: begin
				if (kind_q == K_WRITE && !zero_val) begin
					if (full) st_q <= ST_FULL;
					else fout_q <= fill_q + 1'b1;
				end
			end
			S_MV_WR: begin
				if (more) k_q <= k_q + 1'b1;
				else fout_q <= fill_q - 1'b1;
			end
			S_SUM:   res_q <= mac_sum;
			default: ;
		endcase
		if (done_ld) begin
			ov_res_q  <= res_q;
			ov_fill_q <= 4'(fout_q);
			ov_st_q   <= st_q;
		end
	end

	assign out_valid    = ov_q;
	assign result_value = ov_res_q;
	assign row_fill     = ov_fill_q;
	assign status       = ov_st_q;

endmodule

### rtl/banded_sparse_row_store_top.sv
`timescale 1ns / 1ps
// Top level of the banded sparse row store.
//
//  channel | handshake            | word
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | kind, row, column, value
//  out     | out_valid/out_ready  | result_value, row_fill, status
//
// A load or range error goes straight from the fill lookup to the result. Read,
// write and delete scan the row's slots one by one, a delete then moves each later
// slot down one place, and multiply reads each slot and its vector entry and then
// waits for the accumulator; the single slot memory read port serialises the scans.
// After reset a clearing pass over max(ROWS, COLS) addresses zeroes fill counts and
// vector; in_ready stays low meanwhile. Config writes are always taken.
// The output register frees the core while a result waits on out_ready.
module banded_sparse_row_store_top import bsrs_pkg::*; #(
	parameter int ROWS = 64,
	parameter int COLS = 64,
	parameter int BAND = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [5:0]  row,
	input  logic [5:0]  column,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [3:0]  row_fill,
	output logic [1:0]  status
);

	cfg_t     cfg_q;
	mac_ctl_t mac_ctl;
	logic     mac_busy;
	logic [31:0] mac_sum;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rows_in_use: 7'd64, columns_in_use: 7'd64, band_in_use: 4'd8};
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROWS: cfg_q.rows_in_use    <= cfg_data;
				CFG_COLS: cfg_q.columns_in_use <= cfg_data;
				CFG_BAND: cfg_q.band_in_use    <= cfg_data[3:0];
				default:  ;
			endcase
		end
	end

	bsrs_seq #(.ROWS(ROWS), .COLS(COLS), .BAND(BAND)) u_seq (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid, .in_ready, .kind, .row, .column, .value,
		.out_valid, .out_ready, .result_value, .row_fill, .status,
		.mac_ctl, .mac_busy, .mac_sum
	);

	bsrs_mac u_mac (
		.clk, .arst_n, .ctl(mac_ctl), .busy(mac_busy), .sum(mac_sum)
	);

endmodule

### rtl/bsrs_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the banded sparse row store, bound to the top.
module bsrs_chk import bsrs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result_value,
	input logic [1:0]  status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
		else $error("result word changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> result_value == '0)
		else $error("error result carries a value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != ST_NONE)
		else $error("undefined status code");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("took a word while busy");

endmodule

bind banded_sparse_row_store_top bsrs_chk u_chk (.*);

### sim/banded_sparse_row_store_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the banded sparse row store top level.
module banded_sparse_row_store_top_test;
	import bsrs_pkg::*;

	typedef struct {
		logic [31:0] result_value;
		logic [3:0]  row_fill;
		status_t     status;
	} store_result_t;

	class row_store_scoreboard;
		logic [6:0]  rows_lim;
		logic [6:0]  cols_lim;
		logic [3:0]  band_lim;
		logic [31:0] entry_value [64][8];
		logic [5:0]  entry_column [64][8];
		int          fill [64];
		logic [31:0] vec [64];
		store_result_t pending [$];
		int          errors;

		function new();
			rows_lim = 64;
			cols_lim = 64;
			band_lim = 8;
			errors = 0;
			foreach (fill[i]) fill[i] = 0;
			foreach (vec[i]) vec[i] = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [6:0] data);
			case (idx)
				CFG_ROWS: rows_lim = data;
				CFG_COLS: cols_lim = data;
				CFG_BAND: band_lim = data[3:0];
				default: ;
			endcase
		endfunction

		function void note_item(kind_t k, logic [5:0] r, logic [5:0] c, logic [31:0] v);
			store_result_t res;
			bit row_ok, col_ok;
			int hit, band, n;
			longint sum, prod;
			row_ok = r < rows_lim;
			col_ok = c < cols_lim;
			band = band_lim < 8 ? band_lim : 8;
			res.result_value = '0;
			res.status = ST_OK;
			hit = -1;
			if (row_ok)
				for (int i = 0; i < fill[r]; i++)
					if (hit < 0 && entry_column[r][i] == c) hit = i;
			case (k)
				K_WRITE, K_READ: begin
					if (!row_ok || !col_ok) begin
						res.status = ST_RANGE;
					end else if (k == K_READ) begin
						if (hit >= 0) res.result_value = entry_value[r][hit];
					end else if (v != 0) begin
						if (hit >= 0) begin
							entry_value[r][hit] = v;
						end else if (fill[r] >= band) begin
							res.status = ST_FULL;
						end else begin
							entry_value[r][fill[r]] = v;
							entry_column[r][fill[r]] = c;
							fill[r]++;
						end
					end else if (hit >= 0) begin
						for (int i = hit + 1; i < fill[r]; i++) begin
							entry_value[r][i-1] = entry_value[r][i];
							entry_column[r][i-1] = entry_column[r][i];
						end
						fill[r]--;
					end
				end
				K_LOAD: begin
					if (!col_ok) res.status = ST_RANGE;
					else vec[c] = v;
				end
				default: begin
					if (!row_ok) begin
						res.status = ST_RANGE;
					end else begin
						sum = 0;
						n = fill[r];
						for (int i = 0; i < n; i++) begin
							prod = longint'($signed(entry_value[r][i]))
								* longint'($signed(vec[entry_column[r][i]]));
							sum += (prod + 32768) >>> 16;
						end
						if (sum > 64'sd2147483647) sum = 64'sd2147483647;
						if (sum < -64'sd2147483648) sum = -64'sd2147483648;
						res.result_value = sum[31:0];
					end
				end
			endcase
			res.row_fill = row_ok ? 4'(fill[r]) : 4'd0;
			pending.push_back(res);
		endfunction

		function void check_result(logic [31:0] rv, logic [3:0] rf, logic [1:0] st);
			store_result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word value=%h fill=%0d status=%0d", $time, rv, rf, st);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (rv !== e.result_value) begin
				$display("%0t: result_value expected %h actual %h", $time, e.result_value, rv);
				errors++;
			end
			if (rf !== e.row_fill) begin
				$display("%0t: row_fill expected %0d actual %0d", $time, e.row_fill, rf);
				errors++;
			end
			if (st !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [6:0]  cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [5:0]  row;
	logic [5:0]  column;
	logic [31:0] value;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_value;
	logic [3:0]  row_fill;
	logic [1:0]  status;

	row_store_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_off;

	banded_sparse_row_store_top u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				sb.check_result(result_value, row_fill, status);
			out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(cfg_idx_t idx, logic [6:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(kind_t k, logic [5:0] r, logic [5:0] c, logic [31:0] v);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		kind <= k;
		row <= r;
		column <= c;
		value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_item(k, r, c, v);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return $urandom_range(1, 3) << 16;
			4: return -($urandom_range(1, 3) << 16);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_items(int n, int rmax, int cmax);
		kind_t k;
		logic [5:0] r, c;
		for (int i = 0; i < n; i++) begin
			k = kind_t'($urandom_range(3));
			r = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(rmax));
			c = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(cmax));
			send_item(k, r, c, rand_value());
		end
	endtask

	initial begin
		sb = new();
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NONE;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = K_WRITE;
		row = '0;
		column = '0;
		value = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every kind, band full, delete, miss, range errors
		send_item(K_MUL, 6'd63, 6'd0, 32'h0);
		send_item(K_LOAD, 6'd0, 6'd0, 32'h7fffffff);
		send_item(K_LOAD, 6'd0, 6'd63, 32'h80000000);
		send_item(K_LOAD, 6'd0, 6'd1, 32'hffff0000);
		for (int i = 0; i < 9; i++)
			send_item(K_WRITE, 6'd63, 6'(i == 8 ? 63 : i), 32'h7fffffff);
		send_item(K_MUL, 6'd63, 6'd0, 32'h0);
		send_item(K_WRITE, 6'd63, 6'd1, 32'h0);
		send_item(K_READ, 6'd63, 6'd1, 32'h0);
		send_item(K_READ, 6'd63, 6'd2, 32'h0);
		send_item(K_WRITE, 6'd63, 6'd40, 32'h0);
		send_item(K_WRITE, 6'd0, 6'd63, 32'h80000000);
		send_item(K_WRITE, 6'd0, 6'd0, 32'h80000000);
		send_item(K_MUL, 6'd0, 6'd0, 32'h0);
		drain();
		write_reg(CFG_ROWS, 7'd1);
		write_reg(CFG_COLS, 7'd1);
		write_reg(CFG_BAND, 7'd0);
		send_item(K_WRITE, 6'd0, 6'd1, 32'h1);
		send_item(K_LOAD, 6'd0, 6'd1, 32'h1);
		send_item(K_MUL, 6'd1, 6'd0, 32'h0);
		send_item(K_WRITE, 6'd0, 6'd0, 32'h5);
		send_item(K_MUL, 6'd0, 6'd0, 32'h0);
		drain();

		send_idle_pct = 6;
		recv_idle_pct = 81;
		write_reg(CFG_ROWS, 7'd4);
		write_reg(CFG_COLS, 7'd8);
		write_reg(CFG_BAND, 7'd3);
		random_items(170, 5, 9);
		drain();

		send_idle_pct = 81;
		recv_idle_pct = 6;
		write_reg(CFG_ROWS, 7'd64);
		write_reg(CFG_COLS, 7'd64);
		write_reg(CFG_BAND, 7'd8);
		random_items(150, 7, 12);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_BAND, 7'd15);
		fork
			begin
				hold_off = 1'b1;
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			random_items(30, 3, 10);
		join
		random_items(150, 63, 63);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### banded_sparse_row_store_top.f
rtl/bsrs_pkg.sv
rtl/bsrs_mac.sv
rtl/bsrs_seq.sv
rtl/banded_sparse_row_store_top.sv
rtl/bsrs_chk.sv
sim/banded_sparse_row_store_top_test.sv
